@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define AVI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define AVI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/avi_pkg.sv @@
package avi_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DT    = 2'd2;

  localparam logic [15:0] ALPHA_RESET  = 16'd3277;
  localparam logic [31:0] MAX_DT_RESET = 32'd500000;
  localparam logic signed [23:0] ONE_G_Q20 = 24'sh100000;
  localparam logic [19:0] G_Q16 = 20'd642690;
  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef struct packed {
    logic        has_sample;
    logic [31:0] timestamp_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] g_load;
    logic        g_load_valid;
    logic signed [31:0] vario_in;
    logic        vario_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vario_out;
    logic        vario_adjusted;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } ser_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } ser_rsp_t;

endpackage

@@ sv/avi_stream_if.sv @@
interface avi_in_if;
  logic                valid;
  logic                ready;
  avi_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface avi_out_if;
  logic                valid;
  logic                ready;
  avi_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface avi_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [avi_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                      wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ sv/accel_vario_increment.sv @@
// Channel   Direction  Payload
// in_*      sink       accelerometer sample, g-load, timestamp, vario
// out_*     source     vario_out, vario_adjusted
// cfg_*     sink       register index and write data
// An item without a sample, or with the feature off, goes straight to the output
// state. A sample takes the squares, the square root and a store, which ends the
// first sample. Later samples add reads of a window of n stored values
// (n = min(count, WINDOW)), a divide for the average and the filter, gravity and
// multiply steps; an adjusted item adds a divide by one million.
// One item is in flight at a time, with an idle state before the next accept; reset
// is synchronous. A full output register stalls the finished item until out_ready.
module accel_vario_increment #(
  parameter int unsigned WINDOW        = 30,
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  avi_in_if.sink   in_ch,
  avi_out_if.source out_ch,
  avi_cfg_if.sink  cfg_ch
);
`include "assert_macros.svh"

  localparam int unsigned PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned NMAX = (WINDOW < HISTORY_DEPTH) ? WINDOW : HISTORY_DEPTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQRT = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_SUMW = 4'd4;
  localparam logic [3:0] S_AVG  = 4'd5;
  localparam logic [3:0] S_FILT = 4'd6;
  localparam logic [3:0] S_GRAV = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_SQ   = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic        en_r;
  logic [15:0] alpha_r;
  logic [31:0] maxdt_r;

  avi_pkg::in_item_t  it_r;
  avi_pkg::out_item_t res_r;
  avi_pkg::out_item_t out_r;
  logic               ovalid_r;

  logic [16:0] mem [HISTORY_DEPTH];
  logic [16:0] rd_r;
  logic [PW-1:0] wp_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   last_ts_r;
  logic signed [23:0] fg_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] left_r;
  logic [CW-1:0] n_r;
  logic [22:0]   sum_r;
  logic [31:0]   prev_ts_r;
  logic [31:0]   sq_r;
  logic [1:0]    sqi_r;
  logic          neg_r;
  logic signed [31:0] net_r;
  logic [31:0]   dt_r;
  logic [16:0]   avg_r;

  avi_pkg::ser_req_t sq_req, dv_req;
  avi_pkg::ser_rsp_t sq_rsp, dv_rsp;
  logic [31:0] dv_hi;
  logic [63:0] dv_q;

  avi_isqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));
  avi_divider u_div (.clk(clk), .rst_n(rst_n), .req(dv_req), .dividend_hi(dv_hi),
                     .rsp(dv_rsp), .quotient(dv_q));

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = out_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // The finished item moves to the output register once that register is free.
  logic out_load;
  assign out_load = (st_r == S_OUT) && (!ovalid_r || out_ch.ready);

  // The count and window length once the current sample is stored.
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] n_win;
  assign cnt_inc = (cnt_r < CW'(HISTORY_DEPTH)) ? cnt_r + CW'(1) : cnt_r;
  assign n_win   = (cnt_inc < CW'(NMAX)) ? cnt_inc : CW'(NMAX);

  // Squares are accumulated one axis per cycle.
  logic signed [15:0] axis;
  always_comb begin
    case (sqi_r)
      2'd0:    axis = it_r.accel_x;
      2'd1:    axis = it_r.accel_y;
      default: axis = it_r.accel_z;
    endcase
  end
  logic signed [31:0] axsq;
  assign axsq = axis * axis;

  // Filter and gravity arithmetic, each a single narrow multiply per cycle.
  logic signed [24:0] graw, gd;
  logic signed [42:0] fprod;
  logic signed [26:0] fstep;
  logic signed [25:0] fnew;
  assign graw  = it_r.g_load_valid ? 25'(signed'({it_r.g_load, 8'd0})) : 25'(avi_pkg::ONE_G_Q20);
  assign gd    = graw - 25'(fg_r);
  assign fprod = gd * $signed({1'b0, alpha_r}) + 43'sd32768;
  assign fstep = 27'(fprod >>> 16);
  assign fnew  = 26'(fg_r) + 26'(fstep);

  logic signed [44:0] gprod;
  assign gprod = fg_r * $signed({1'b0, avi_pkg::G_Q16}) + 45'sd524288;
  logic signed [24:0] grav;
  assign grav = 25'(gprod >>> 20);

  logic signed [63:0] mag_prod;
  logic [63:0] abs_prod;
  assign mag_prod = 64'(net_r) * $signed({1'b0, dt_r});
  assign abs_prod = mag_prod[63] ? 64'(-mag_prod) : 64'(mag_prod);

  // The increment can exceed 32 bits for long intervals, so 40 quotient bits are kept.
  logic signed [40:0] quo_s;
  logic signed [41:0] vsum;
  assign quo_s = neg_r ? -$signed({1'b0, dv_q[39:0]}) : $signed({1'b0, dv_q[39:0]});
  assign vsum  = 42'(it_r.vario_in) + 42'(quo_s);

  always_comb begin
    st_nxt = st_r;
    sq_req = '0;
    dv_req = '0;
    dv_hi  = '0;
    case (st_r)
      S_IDLE: if (in_fire) begin
        st_nxt = (en_r && in_ch.data.has_sample) ? S_SQ : S_OUT;
      end
      S_SQ:    if (sqi_r == 2'd2) begin
        st_nxt = S_SQRT;
        sq_req.start = 1'b1;
        sq_req.op_a  = sq_r + axsq;
      end
      S_SQRT:  if (sq_rsp.done) st_nxt = S_STORE;
      S_STORE: st_nxt = (cnt_inc >= CW'(2)) ? S_SUM : S_OUT;
      S_SUM:   st_nxt = S_SUMW;
      S_SUMW:  if (left_r == '0) begin
        st_nxt = S_AVG;
        dv_req.start = 1'b1;
        dv_req.op_a  = 32'(sum_r) + 32'(rd_r);
        dv_req.op_b  = 32'(n_r);
      end
      S_AVG:   if (dv_rsp.done) st_nxt = S_FILT;
      S_FILT:  st_nxt = S_GRAV;
      S_GRAV:  st_nxt = S_MUL;
      S_MUL: begin
        if (dt_r != '0 && dt_r <= maxdt_r && it_r.vario_valid) begin
          st_nxt = S_DIV;
          dv_req.start = 1'b1;
          dv_req.op_a  = abs_prod[31:0];
          dv_hi        = abs_prod[63:32];
          dv_req.op_b  = 32'(avi_pkg::US_PER_S);
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_DIV:   if (dv_rsp.done) st_nxt = S_OUT;
      S_OUT:   st_nxt = out_load ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_STORE) mem[wp_r] <= sq_rsp.res[16:0];
    rd_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_r  <= in_ch.data;
      sq_r  <= '0;
      sqi_r <= '0;
      res_r <= '{vario_out: in_ch.data.vario_in, vario_adjusted: 1'b0};
    end
    if (out_load) out_r <= res_r;
    case (st_r)
      S_SQ: begin
        sq_r  <= sq_r + axsq;
        sqi_r <= sqi_r + 2'd1;
      end
      S_STORE: begin
        prev_ts_r <= last_ts_r;
        rp_r      <= wp_r;
        n_r       <= n_win;
        left_r    <= n_win - CW'(1);
        sum_r     <= '0;
      end
      S_SUM: begin
        rp_r   <= (rp_r == '0) ? PW'(HISTORY_DEPTH - 1) : rp_r - PW'(1);
      end
      S_SUMW: if (left_r != '0) begin
        sum_r  <= sum_r + 23'(rd_r);
        left_r <= left_r - CW'(1);
        rp_r   <= (rp_r == '0) ? PW'(HISTORY_DEPTH - 1) : rp_r - PW'(1);
      end
      S_AVG: if (dv_rsp.done) avg_r <= dv_rsp.res[16:0];
      S_GRAV: begin
        net_r <= 32'({avg_r, 8'd0}) - 32'(grav);
        dt_r  <= it_r.timestamp_us - prev_ts_r;
      end
      S_MUL: neg_r <= mag_prod[63];
      S_DIV: if (dv_rsp.done) begin
        res_r.vario_adjusted <= 1'b1;
        if (vsum > 42'sd2147483647) res_r.vario_out <= 32'sh7fffffff;
        else if (vsum < -42'sd2147483648) res_r.vario_out <= 32'sh80000000;
        else res_r.vario_out <= vsum[31:0];
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ovalid_r  <= 1'b0;
      en_r      <= 1'b0;
      alpha_r   <= avi_pkg::ALPHA_RESET;
      maxdt_r   <= avi_pkg::MAX_DT_RESET;
      wp_r      <= '0;
      cnt_r     <= '0;
      last_ts_r <= '0;
      fg_r      <= avi_pkg::ONE_G_Q20;
    end else begin
      st_r <= st_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          avi_pkg::REG_ENABLE:    en_r    <= cfg_ch.wdata[0];
          avi_pkg::REG_LPF_ALPHA: alpha_r <= cfg_ch.wdata[15:0];
          avi_pkg::REG_MAX_DT:    maxdt_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (st_r == S_STORE) begin
        wp_r      <= (wp_r == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + PW'(1);
        cnt_r     <= cnt_inc;
        last_ts_r <= it_r.timestamp_us;
      end
      if (st_r == S_FILT) begin
        if (fnew > 26'sd8388607) fg_r <= 24'sh7fffff;
        else if (fnew < -26'sd8388608) fg_r <= 24'sh800000;
        else fg_r <= fnew[23:0];
      end
    end
  end

  `AVI_ASSERT(a_one_out, clk, rst_n, (ovalid_r && !out_ch.ready) |=> ovalid_r, "result dropped")
  `AVI_ASSERT(a_out_hold, clk, rst_n, (ovalid_r && !out_ch.ready) |=> $stable(out_r), "result changed")
  `AVI_ASSERT(a_no_in_busy, clk, rst_n, (st_r != S_IDLE) |-> !in_ch.ready, "accepted while busy")
  `AVI_ASSERT(a_cnt_rng, clk, rst_n, 1'b1 |-> (cnt_r <= CW'(HISTORY_DEPTH)), "count overflow")
endmodule

@@ sv/avi_isqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
module avi_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  avi_pkg::ser_req_t   req,
  output avi_pkg::ser_rsp_t   rsp
);
  logic [31:0] rad_r, rad_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [17:0] shifted;

  always_comb begin
    shifted  = {rem_r[15:0], rad_r[31:30]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rad_nxt  = req.op_a;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[29:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = {16'd0, root_r};
endmodule

@@ sv/avi_divider.sv @@
// Bit-serial restoring divider for unsigned 64/32 quotients, one bit per cycle.
// op_a holds the low half of the dividend; hi is loaded through dividend_hi.
module avi_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  avi_pkg::ser_req_t   req,
  input  logic [31:0]         dividend_hi,
  output avi_pkg::ser_rsp_t   rsp,
  output logic [63:0]         quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    sh       = {rem_r[31:0], quo_r[63]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = {dividend_hi, req.op_a};
      rem_nxt  = '0;
      den_nxt  = req.op_b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = quo_r[31:0];
  assign quotient = quo_r;
endmodule
